@@ design/lsdk_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsdk_pkg
// shared widths and codes for the longest divisible-sum subarray unit
// ----------------------------------------------------------------------------
package lsdk_pkg;

  localparam int MAX_DIVISOR = 1024;
  localparam int MAX_ITEMS   = 65536;

  localparam int ELEM_W  = 18;
  localparam int DIV_W   = 11;
  localparam int LEN_W   = 17;
  localparam int IDX_W   = $clog2(MAX_ITEMS);
  localparam int REM_W   = $clog2(MAX_DIVISOR);

  localparam int MOD_STEPS = 4;
  localparam int MAG_W     = 20;
  localparam int MOD_CYC   = MAG_W / MOD_STEPS;
  localparam int MOD_CNT_W = $clog2(MOD_CYC);
  localparam int MOD_R_W   = DIV_W + 1;

  localparam int EPOCH_W  = 8;
  localparam int ENTRY_W  = EPOCH_W + IDX_W;

  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic REG_DIVISOR = 1'b0;

  localparam logic [DIV_W-1:0] DIVISOR_RESET = DIV_W'(1);
  localparam logic [DIV_W-1:0] DIVISOR_MAX   = DIV_W'(MAX_DIVISOR);

endpackage : lsdk_pkg
`default_nettype wire

@@ design/lsdk_mod_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsdk_mod_unit
// iterative floored modulo of a signed sum by a run-time divisor
// ----------------------------------------------------------------------------
module lsdk_mod_unit
  import lsdk_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [MAG_W-1:0]   mag_i,
  input  wire logic               neg_i,
  input  wire logic [DIV_W-1:0]   k_i,
  output logic                    done_o,
  output logic [REM_W-1:0]        rem_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [MOD_CNT_W-1:0] cnt_q, cnt_d;
  logic [MAG_W-1:0]     shift_q, shift_d;
  logic [MOD_R_W-1:0]   r_q, r_d;
  logic                 neg_q, neg_d;
  logic [DIV_W-1:0]     k_q, k_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic [MOD_R_W-1:0]   r_w;
  logic [MAG_W-1:0]     sh_w;
  logic [MOD_R_W-1:0]   fix_w;

  always_comb begin
    r_w  = r_q;
    sh_w = shift_q;
    for (int j = 0; j < MOD_STEPS; j++) begin
      r_w  = {r_w[MOD_R_W-2:0], sh_w[MAG_W-1]};
      sh_w = {sh_w[MAG_W-2:0], 1'b0};
      if (r_w >= {1'b0, k_q}) begin
        r_w = r_w - {1'b0, k_q};
      end
    end
    if (neg_q && (r_w != '0)) begin
      fix_w = {1'b0, k_q} - r_w;
    end else begin
      fix_w = r_w;
    end
  end

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    shift_d = shift_q;
    r_d     = r_q;
    neg_d   = neg_q;
    k_d     = k_q;
    rem_d   = rem_q;
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = '0;
      shift_d = mag_i;
      r_d     = '0;
      neg_d   = neg_i;
      k_d     = k_i;
    end else if (busy_q) begin
      shift_d = sh_w;
      r_d     = r_w;
      cnt_d   = cnt_q + MOD_CNT_W'(1);
      if (cnt_q == MOD_CNT_W'(MOD_CYC - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        rem_d  = fix_w[REM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    r_q     <= r_d;
    neg_q   <= neg_d;
    k_q     <= k_d;
    rem_q   <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule : lsdk_mod_unit
`default_nettype wire

@@ design/longest_subarray_sum_div_k_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// longest_subarray_sum_div_k_unit
// longest run of items whose sum divides by a configured divisor
// ----------------------------------------------------------------------------
// items: a new item is taken only once the last has passed the 4-bit-per-cycle
//   modulo unit and the read-modify-write of the first-index table, which also
//   registers the result after a final item
// reset: a clearing pass of all 1024 table entries runs after reset and after
//   every 255th array, and no item is accepted during it
// ----------------------------------------------------------------------------
module longest_subarray_sum_div_k_unit
  import lsdk_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [PADDR_W-1:0]       paddr,
  input  wire logic [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]            prdata,
  output logic                          pready,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [ELEM_W-1:0] element_i,
  input  wire logic                     final_element_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [LEN_W-1:0]              longest_length_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_UPD   = 3'd3;

  logic [2:0]         state_q, state_d;
  logic [DIV_W-1:0]   divisor_q, divisor_d;
  logic [REM_W-1:0]   prefix_q, prefix_d;
  logic [IDX_W-1:0]   index_q, index_d;
  logic [LEN_W-1:0]   best_q, best_d;
  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic [REM_W-1:0]   clr_q, clr_d;
  logic               final_q, final_d;
  logic [REM_W-1:0]   rem_q, rem_d;
  logic               out_valid_q, out_valid_d;
  logic [LEN_W-1:0]   out_len_q, out_len_d;

  logic [ENTRY_W-1:0] mem_q [MAX_DIVISOR];
  logic [ENTRY_W-1:0] rd_data_q;
  logic [REM_W-1:0]   rd_addr;
  logic               wr_en;
  logic [REM_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  logic [DIV_W-1:0]   k_eff;
  logic               in_acc;
  logic [MAG_W-1:0]   sum_w;
  logic [MAG_W-1:0]   mag_w;
  logic               mod_done;
  logic [REM_W-1:0]   mod_rem;
  logic [IDX_W-1:0]   first_idx;
  logic               hit;
  logic [LEN_W-1:0]   cand;
  logic [LEN_W-1:0]   best_new;
  logic               cfg_wr;

  // divisor register
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_comb begin
    divisor_d = divisor_q;
    if (cfg_wr && (paddr[2] == REG_DIVISOR)) begin
      divisor_d = pwdata[DIV_W-1:0];
    end
    if (paddr[2] == REG_DIVISOR) begin
      prdata = {{(PDATA_W-DIV_W){1'b0}}, divisor_q};
    end else begin
      prdata = '0;
    end
  end

  always_comb begin
    if (divisor_q == '0) begin
      k_eff = DIV_W'(1);
    end else if (divisor_q > DIVISOR_MAX) begin
      k_eff = DIVISOR_MAX;
    end else begin
      k_eff = divisor_q;
    end
  end

  // prefix plus element, split into sign and magnitude
  assign in_acc = in_valid_i && in_ready_o;
  assign sum_w  = {{(MAG_W-ELEM_W){element_i[ELEM_W-1]}}, element_i}
                + {{(MAG_W-REM_W){1'b0}}, prefix_q};
  assign mag_w  = sum_w[MAG_W-1] ? (~sum_w + MAG_W'(1)) : sum_w;

  lsdk_mod_unit u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .mag_i   (mag_w),
    .neg_i   (sum_w[MAG_W-1]),
    .k_i     (k_eff),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  // first-index table
  assign rd_addr = (state_q == ST_DIV) ? mod_rem : rem_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  assign first_idx = rd_data_q[IDX_W-1:0];
  assign hit       = (rd_data_q[ENTRY_W-1:IDX_W] == epoch_q);

  always_comb begin
    if (rem_q == '0) begin
      cand = {1'b0, index_q} + LEN_W'(1);
    end else if (hit && (index_q >= first_idx)) begin
      cand = {1'b0, index_q - first_idx};
    end else begin
      cand = '0;
    end
    best_new = (cand > best_q) ? cand : best_q;
  end

  always_comb begin
    state_d     = state_q;
    prefix_d    = prefix_q;
    index_d     = index_q;
    best_d      = best_q;
    epoch_d     = epoch_q;
    clr_d       = clr_q;
    final_d     = final_q;
    rem_d       = rem_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_len_d   = out_len_q;
    wr_en       = 1'b0;
    wr_addr     = rem_q;
    wr_data     = {epoch_q, index_q};
    in_ready_o  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
        clr_d   = clr_q + REM_W'(1);
        if (clr_q == REM_W'(MAX_DIVISOR - 1)) begin
          epoch_d = EPOCH_W'(1);
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          final_d = final_element_i;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (mod_done) begin
          rem_d   = mod_rem;
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (!(final_q && out_valid_q && !out_ready_i)) begin
          wr_en    = (rem_q != '0) && !hit;
          prefix_d = rem_q;
          best_d   = best_new;
          if (index_q != IDX_W'(MAX_ITEMS - 1)) begin
            index_d = index_q + IDX_W'(1);
          end
          state_d = ST_IDLE;
          if (final_q) begin
            out_valid_d = 1'b1;
            out_len_d   = best_new;
            prefix_d    = '0;
            index_d     = '0;
            best_d      = '0;
            if (epoch_q == '1) begin
              clr_d   = '0;
              state_d = ST_CLEAR;
            end else begin
              epoch_d = epoch_q + EPOCH_W'(1);
            end
          end
        end
      end
      default: begin
        state_d = ST_CLEAR;
        clr_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      divisor_q   <= DIVISOR_RESET;
      prefix_q    <= '0;
      index_q     <= '0;
      best_q      <= '0;
      epoch_q     <= EPOCH_W'(1);
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      divisor_q   <= divisor_d;
      prefix_q    <= prefix_d;
      index_q     <= index_d;
      best_q      <= best_d;
      epoch_q     <= epoch_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    final_q   <= final_d;
    rem_q     <= rem_d;
    out_len_q <= out_len_d;
  end

  assign out_valid_o      = out_valid_q;
  assign longest_length_o = out_len_q;

endmodule : longest_subarray_sum_div_k_unit
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for longest_subarray_sum_div_k_unit. Arrays of signed
// elements are streamed under random bursts and output stalls. A prefix
// remainder tracker predicts each longest length and compares it with the
// result port. The run covers divisor extremes (zero, full scale and above),
// a divisor change in the middle of an array, and many short arrays across
// the table clearing passes.
// ----------------------------------------------------------------------------
module tb_top
  import lsdk_pkg::*;
;

  localparam int SETTLE_CYCLES = 32;
  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int PHASE_ITEMS   = 82;

  typedef struct {
    logic [ELEM_W-1:0] element;
    logic              is_last;
  } element_item_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [PADDR_W-1:0]       paddr = '0;
  logic [PDATA_W-1:0]       pwdata = '0;
  logic [PDATA_W-1:0]       prdata;
  logic                     pready;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic signed [ELEM_W-1:0] element_i = '0;
  logic                     final_element_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [LEN_W-1:0]         longest_length_o;

  // prefix remainder tracker
  logic [DIV_W-1:0]  divisor_reg = DIVISOR_RESET;
  logic [REM_W-1:0]  prefix_rem = '0;
  logic [IDX_W-1:0]  item_idx = '0;
  logic [LEN_W-1:0]  best_len = '0;
  logic [IDX_W-1:0]  first_idx [MAX_DIVISOR];
  bit                rem_seen [MAX_DIVISOR];

  logic [LEN_W-1:0]  expected_lengths [$];
  element_item_t     pending_items [$];
  element_item_t     next_item;
  logic [LEN_W-1:0]  want_len;

  int  fail_count = 0;
  int  items_seen = 0;
  int  results_seen = 0;
  int  divisor_writes = 0;
  int  array_len = 0;
  int  longest_array = 0;
  int  cycle_count = 0;
  int  burst_left = 0;
  int  gap_left = 0;
  int  ready_mode = 0;
  int  ready_left = 0;
  bit  sender_steady = 1'b0;

  longest_subarray_sum_div_k_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .element_i        (element_i),
    .final_element_i  (final_element_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .longest_length_o (longest_length_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int effective_divisor(input logic [DIV_W-1:0] d);
    if (d == '0) return 1;
    if (int'(d) > MAX_DIVISOR) return MAX_DIVISOR;
    return int'(d);
  endfunction

  function automatic void track_element(input logic [ELEM_W-1:0] raw, input logic is_last);
    int k;
    int e;
    int m;
    int erem;
    int r;
    int run;
    k = effective_divisor(divisor_reg);
    e = int'($signed(raw));
    m = e % k;
    erem = (m < 0) ? m + k : m;
    r = (int'(prefix_rem) % k + erem) % k;
    prefix_rem = REM_W'(r);
    if (r == 0) begin
      if (int'(item_idx) + 1 > int'(best_len)) best_len = LEN_W'(int'(item_idx) + 1);
    end else if (!rem_seen[r]) begin
      rem_seen[r] = 1'b1;
      first_idx[r] = item_idx;
    end else begin
      run = (item_idx >= first_idx[r]) ? int'(item_idx) - int'(first_idx[r]) : 0;
      if (run > int'(best_len)) best_len = LEN_W'(run);
    end
    if (int'(item_idx) < MAX_ITEMS - 1) item_idx = item_idx + 1'b1;
    array_len++;
    if (is_last) begin
      expected_lengths.push_back(best_len);
      if (array_len > longest_array) longest_array = array_len;
      array_len = 0;
      prefix_rem = '0;
      item_idx = '0;
      best_len = '0;
      foreach (rem_seen[j]) rem_seen[j] = 1'b0;
    end
  endfunction

  function automatic logic [ELEM_W-1:0] pick_element(input int k);
    int base;
    int off;
    case ($urandom_range(0, 5))
      0: return ELEM_W'($urandom);
      1: return ELEM_W'(int'($urandom_range(0, 200000)) - 100000);
      2: begin
        case ($urandom_range(0, 5))
          0: return ELEM_W'(-100000);
          1: return ELEM_W'(100000);
          2: return ELEM_W'(-131072);
          3: return ELEM_W'(131071);
          4: return '0;
          default: return '1;
        endcase
      end
      default: begin
        // multiples of k plus a few offsets keep remainders repeating
        base = k * (int'($urandom_range(0, 40)) - 20);
        case ($urandom_range(0, 3))
          0: off = 0;
          1: off = 1;
          2: off = k - 1;
          default: off = int'($urandom_range(0, k - 1));
        endcase
        return ELEM_W'(base + off);
      end
    endcase
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid_i || in_ready_o) begin
      if (gap_left > 0 && !sender_steady) begin
        in_valid_i <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_items.size() != 0) begin
        next_item = pending_items.pop_front();
        in_valid_i <= 1'b1;
        element_i <= next_item.element;
        final_element_i <= next_item.is_last;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 16);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result side stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      ready_left <= 0;
    end else begin
      if (ready_left == 0) begin
        ready_mode <= $urandom_range(0, 2);
        ready_left <= $urandom_range(1, 30);
      end else begin
        ready_left <= ready_left - 1;
      end
      case (ready_mode)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'b0;
        default: out_ready_i <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_lengths.size() == 0) begin
          $error("longest_length: no result expected, actual %0d", longest_length_o);
          fail_count++;
        end else begin
          want_len = expected_lengths.pop_front();
          results_seen++;
          if (longest_length_o !== want_len) begin
            $error("longest_length mismatch: expected %0d, actual %0d",
                   want_len, longest_length_o);
            fail_count++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        items_seen++;
        track_element(element_i, final_element_i);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic drain();
    @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_lengths.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic set_divisor(input int value);
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * int'(REG_DIVISOR));
    pwdata <= PDATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    divisor_reg = DIV_W'(value);
    divisor_writes++;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[DIV_W-1:0] !== DIV_W'(value)) begin
      $error("divisor readback mismatch: expected %0d, actual %0d",
             DIV_W'(value), prdata[DIV_W-1:0]);
      fail_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic push_item(input int value, input bit is_last);
    element_item_t it;
    it.element = ELEM_W'(value);
    it.is_last = is_last;
    pending_items.push_back(it);
  endtask

  task automatic push_arrays(input int count, input bit may_cut);
    int k;
    int len;
    int sent;
    k = effective_divisor(divisor_reg);
    sent = 0;
    @(negedge clk_i);
    while (sent < count) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 3);
      for (int j = 0; j < len; j++) begin
        push_item(int'($signed(pick_element(k))),
                  (j == len - 1) && !(may_cut && sent + len >= count));
      end
      sent += len;
      if ($urandom_range(0, 11) == 0) drain();
    end
  endtask

  initial begin
    int phase_divs[$];
    phase_divs = '{2, 3, 10, 64, 1000, 1023, 1024, 0, 2047, 1};
    phase_divs.push_back($urandom_range(1, 1024));
    phase_divs.push_back($urandom_range(1, 1024));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // divisor at its reset value
    push_item(5, 1'b1);
    push_item(-100000, 1'b0);
    push_item(100000, 1'b1);
    // zero divisor acts as one
    set_divisor(0);
    push_item(7, 1'b0);
    push_item(-3, 1'b1);
    // divisor above full scale saturates
    set_divisor(2047);
    push_item(131071, 1'b0);
    push_item(-131072, 1'b0);
    push_item(-1, 1'b1);
    // zero remainders, repeated remainders, no match at all
    set_divisor(7);
    push_item(1, 1'b0);
    push_item(6, 1'b0);
    push_item(3, 1'b0);
    push_item(3, 1'b0);
    push_item(1, 1'b1);
    push_item(2, 1'b0);
    push_item(7, 1'b0);
    push_item(14, 1'b1);
    push_item(1, 1'b1);
    // divisor changed in the middle of an array
    set_divisor(5);
    push_item(2, 1'b0);
    push_item(3, 1'b0);
    set_divisor(3);
    push_item(4, 1'b0);
    push_item(2, 1'b1);
    set_divisor(1024);
    push_item(1023, 1'b0);
    push_item(1, 1'b1);

    foreach (phase_divs[p]) begin
      set_divisor(phase_divs[p]);
      sender_steady = (p % 4 == 3);
      push_arrays(PHASE_ITEMS, p != phase_divs.size() - 1);
    end

    drain();
    sender_steady = 1'b0;
    push_item(3, 1'b0);
    push_item(-2, 1'b1);

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    $display("run covered %0d items in %0d arrays with %0d divisor writes",
             items_seen, results_seen, divisor_writes);
    $display("longest array %0d items, %0d mismatches", longest_array, fail_count);
    if (fail_count == 0 && expected_lengths.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
